@@ hw/rtl/cdd_pkg.sv @@
// Shared types and constants of the channel disk dilation block.
package cdd_pkg;

	localparam int PIX_W     = 32;
	localparam int FW_W      = 11;
	localparam int FH_W      = 16;
	localparam int RAD_W     = 3;
	localparam int CSEL_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [PIX_W-1:0]  FULL_WHITE    = 32'hffff_ffff;
	localparam logic [FW_W-1:0]   FW_RESET      = 11'd640;
	localparam logic [FH_W-1:0]   FH_RESET      = 16'd480;
	localparam logic [RAD_W-1:0]  RAD_RESET     = 3'd2;
	localparam logic [CSEL_W-1:0] CSEL_RESET    = 2'd3;
	localparam logic [PIX_W-1:0]  SPREAD_RESET  = 32'hffff_ffff;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_DISK_RADIUS    = 3'd2,
		REG_CHANNEL_SELECT = 3'd3,
		REG_SPREAD_COLOR   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic store;
		logic scan_init;
		logic scan_step;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic pix_ok;
		logic emit_req;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/cdd_pix_if.sv @@
// Input channel interface: source pixels and flush ticks.
interface cdd_pix_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [cdd_pkg::PIX_W-1:0] src_pixel;

	modport source(output valid, command, src_pixel, input ready);
	modport sink(input valid, command, src_pixel, output ready);
endinterface

@@ hw/rtl/cdd_res_if.sv @@
// Output channel interface: dilated pixels.
interface cdd_res_if;
	logic                      valid;
	logic                      ready;
	logic [cdd_pkg::PIX_W-1:0] out_pixel;
	logic                      frame_last;

	modport source(output valid, out_pixel, frame_last, input ready);
	modport sink(input valid, out_pixel, frame_last, output ready);
endinterface

@@ hw/rtl/channel_disk_dilation_top.sv @@
// Top level of the channel disk dilation block.
// Usage:
//   pixels carries one frame in raster order (command 0 with src_pixel) and,
//   after the frame, flush ticks (command 1) that drain the last pixels.
//   results returns each pixel delayed by radius rows plus radius pixels,
//   replaced by spread_color (unless full white) where the clipped disk finds
//   a set byte in the selected channel; frame_last marks the final pixel.
//   The user writes registers over cfg_we/cfg_index/cfg_data only while idle;
//   not enforced by the block. Writes to defined indices restart the frame.
// Timing:
//   A transaction that produces no result is done when accepted. One that
//   produces a result scans the disk one neighbor per cycle through the single
//   read port of the set-bit line buffer, then drains the pipeline and loads
//   the result in the emit step.
// Reset: counters return to frame start, registers take their defaults; the
//   line buffers are not cleared.
// Stall: a result waits in the output register; the next transaction is
//   accepted meanwhile and holds in the emit step until the register frees.
module channel_disk_dilation_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdd_pkg::CFG_DATA_W-1:0] cfg_data,
	cdd_pix_if.sink                        pixels,
	cdd_res_if.source                      results
);
	import cdd_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;

	cdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cdd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.command    (pixels.command),
		.src_pixel  (pixels.src_pixel),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_pixel  (results.out_pixel),
		.frame_last (results.frame_last)
	);

endmodule

@@ hw/rtl/cdd_ctrl.sv @@
// Controller: sequences accept, disk scan, pipeline drain and result load.
module cdd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdd_pkg::dp_status_t st,
	output cdd_pkg::ctl_cmd_t   cmd
);
	import cdd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN1 = 5'b00100,
		ST_DRAIN2 = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = st.pix_ok;
					if (st.emit_req) begin
						cmd.scan_init = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/cdd_datapath.sv @@
// Datapath: config registers, frame counters, line buffers, disk scan, output register.
module cdd_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           command,
	input  logic [cdd_pkg::PIX_W-1:0]      src_pixel,
	input  cdd_pkg::ctl_cmd_t              cmd,
	output cdd_pkg::dp_status_t            st,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cdd_pkg::PIX_W-1:0]      out_pixel,
	output logic                           frame_last
);
	import cdd_pkg::*;

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int LW  = WW + FH_W;
	localparam int DLW = RW + WW + 1;
	localparam int SD  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
	localparam int SAW = $clog2(SD);
	localparam int PD  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
	localparam int PAW = $clog2(PD);
	localparam int SW  = RW + 1;
	localparam int OW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1) + 1;
	localparam int AW  = SAW + 2;
	localparam int XW  = WW + 2;
	localparam int YW  = FH_W + 2;
	localparam int QW  = 2 * SW + 1;

	// configuration
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [RAD_W-1:0]  rad_q;
	logic [CSEL_W-1:0] csel_q;
	logic [PIX_W-1:0]  spread_q;
	logic              cfg_hit;

	always_comb begin
		cfg_hit = 1'b0;
		if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_DISK_RADIUS,
				REG_CHANNEL_SELECT, REG_SPREAD_COLOR: cfg_hit = 1'b1;
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= FW_RESET;
			fh_q     <= FH_RESET;
			rad_q    <= RAD_RESET;
			csel_q   <= CSEL_RESET;
			spread_q <= SPREAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:    fw_q     <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT:   fh_q     <= cfg_data[FH_W-1:0];
				REG_DISK_RADIUS:    rad_q    <= cfg_data[RAD_W-1:0];
				REG_CHANNEL_SELECT: csel_q   <= cfg_data[CSEL_W-1:0];
				REG_SPREAD_COLOR:   spread_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [WW-1:0]   w_eff;
	logic [FH_W-1:0] h_eff;
	logic [RW-1:0]   r_eff;
	logic [LW-1:0]   total;
	logic [DLW-1:0]  delay;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
		r_eff = (int'(rad_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_q);
	end

	assign total = LW'(w_eff) * LW'(h_eff);
	assign delay = DLW'(r_eff) * DLW'(w_eff) + DLW'(r_eff);

	// frame counters and buffer pointers
	logic [LW-1:0]   in_lin_q, out_lin_q;
	logic [WW-1:0]   out_col_q;
	logic [FH_W-1:0] out_row_q;
	logic [PAW-1:0]  in_pp_q, out_pp_q;
	logic [SAW-1:0]  in_sp_q, out_sp_q;
	logic            out_done;

	assign out_done = (out_lin_q + LW'(1)) >= total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lin_q  <= '0;
			out_lin_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			in_pp_q   <= '0;
			out_pp_q  <= '0;
			in_sp_q   <= '0;
			out_sp_q  <= '0;
		end else if (cfg_hit || (cmd.emit && out_done)) begin
			in_lin_q  <= '0;
			out_lin_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			in_pp_q   <= '0;
			out_pp_q  <= '0;
			in_sp_q   <= '0;
			out_sp_q  <= '0;
		end else begin
			if (cmd.store) begin
				in_lin_q <= in_lin_q + LW'(1);
				in_pp_q  <= (in_pp_q == PAW'(PD - 1)) ? '0 : in_pp_q + PAW'(1);
				in_sp_q  <= (in_sp_q == SAW'(SD - 1)) ? '0 : in_sp_q + SAW'(1);
			end
			if (cmd.emit) begin
				out_lin_q <= out_lin_q + LW'(1);
				out_pp_q  <= (out_pp_q == PAW'(PD - 1)) ? '0 : out_pp_q + PAW'(1);
				out_sp_q  <= (out_sp_q == SAW'(SD - 1)) ? '0 : out_sp_q + SAW'(1);
				if ((out_col_q + WW'(1)) >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + FH_W'(1);
				end else begin
					out_col_q <= out_col_q + WW'(1);
				end
			end
		end
	end

	// status
	logic pix_ok;
	assign pix_ok = (command == CMD_PIXEL) && (in_lin_q < total);

	// line buffers
	logic              set_mem [SD];
	logic [PIX_W-1:0]  pix_mem [PD];
	logic              set_bit;
	logic [PIX_W-1:0]  pix_rd_q;
	logic              set_rd_s2;
	logic [SAW-1:0]    rd_addr;

	assign set_bit = src_pixel[{csel_q, 3'b000} +: 8] != 8'd0;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			set_mem[in_sp_q] <= set_bit;
		end
		set_rd_s2 <= set_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			pix_mem[in_pp_q] <= src_pixel;
		end
		pix_rd_q <= pix_mem[out_pp_q];
	end

	// disk scan, stage 0
	logic signed [SW-1:0] dy_q, dx_q, r_s;
	logic signed [YW-1:0] ypos;
	logic signed [XW-1:0] xpos;
	logic signed [QW-1:0] dsq, rsq;
	logic signed [OW-1:0] w_s, dy_o, dx_o, off;
	logic                 in_y, in_x, in_disk;

	assign r_s  = SW'(r_eff);
	assign ypos = $signed({2'b00, out_row_q}) + YW'(dy_q);
	assign xpos = $signed({2'b00, out_col_q}) + XW'(dx_q);
	assign in_y = (ypos >= 0) && (ypos < $signed({2'b00, h_eff}));
	assign in_x = (xpos >= 0) && (xpos < $signed({2'b00, w_eff}));
	assign dsq  = QW'(dx_q * dx_q) + QW'(dy_q * dy_q);
	assign rsq  = QW'(r_s * r_s);
	assign in_disk = dsq <= rsq;
	assign w_s  = OW'(w_eff);
	assign dy_o = OW'(dy_q);
	assign dx_o = OW'(dx_q);
	assign off  = OW'(dy_o * w_s) + dx_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dy_q <= '0;
			dx_q <= '0;
		end else if (cmd.scan_init) begin
			dy_q <= -r_s;
			dx_q <= -r_s;
		end else if (cmd.scan_step) begin
			if (dx_q == r_s) begin
				dx_q <= -r_s;
				dy_q <= dy_q + SW'(1);
			end else begin
				dx_q <= dx_q + SW'(1);
			end
		end
	end

	// stage 1: buffer address, stage 2: accumulate
	logic                 en_s1, en_s2, hit_q;
	logic signed [OW-1:0] off_s1;
	logic signed [AW-1:0] asum;

	always_ff @(posedge clk) begin
		off_s1 <= off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			en_s1 <= cmd.scan_step && in_y && in_x && in_disk;
			en_s2 <= en_s1;
			if (cmd.scan_init) begin
				hit_q <= 1'b0;
			end else if (en_s2 && set_rd_s2) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign asum = $signed({2'b00, out_sp_q}) + AW'(off_s1);

	always_comb begin
		if (asum < 0) begin
			rd_addr = SAW'(asum + AW'(SD));
		end else if (asum >= AW'(SD)) begin
			rd_addr = SAW'(asum - AW'(SD));
		end else begin
			rd_addr = SAW'(asum);
		end
	end

	// output register
	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pixel_q, result;

	always_comb begin
		if (pix_rd_q == FULL_WHITE) begin
			result = pix_rd_q;
		end else if (hit_q) begin
			result = spread_q;
		end else begin
			result = pix_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pixel_q <= result;
			out_last_q  <= (out_lin_q + LW'(1)) == total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign frame_last = out_last_q;

	always_comb begin
		st.pix_ok    = pix_ok;
		st.emit_req  = (command == CMD_FLUSH)
			? ((in_lin_q >= total) && (out_lin_q < total))
			: (pix_ok && (in_lin_q >= LW'(delay)));
		st.scan_last = (dy_q == r_s) && (dx_q == r_s);
		st.out_free  = !out_valid_q || out_ready;
	end

endmodule
